// File: src/trie_pkg.sv
// ----------------------------------------------------------------------------
// trie_pkg
// Shared sizes, memory row type and memory request structs for the trie
// dictionary engine.
// ----------------------------------------------------------------------------
package trie_pkg;

  // Trie geometry
  localparam int NODES   = 4096;
  localparam int LETTERS = 26;

  // Derived widths
  localparam int NODE_W = $clog2(NODES);
  localparam int FREE_W = $clog2(NODES + 1);
  localparam int LIDX_W = (LETTERS > 1) ? $clog2(LETTERS) : 1;
  localparam int LET_W  = 5;

  // Input function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // One row of the link memory: one child link per letter, zero = no link
  typedef logic [LETTERS-1:0][NODE_W-1:0] link_row_t;

  // Link memory access, one read and one write port
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              we;
    logic [NODE_W-1:0] wr_addr;
    link_row_t         wdata;
  } link_req_t;

  // Mark memory access: shared read address, separate write ports
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              word_we;
    logic [NODE_W-1:0] word_addr;
    logic              word_bit;
    logic              child_we;
    logic [NODE_W-1:0] child_addr;
    logic              child_bit;
  } mark_req_t;

  // Mark memory read data
  typedef struct packed {
    logic is_word;
    logic has_children;
  } mark_rd_t;

endpackage

// File: src/trie_link_mem.sv
// ----------------------------------------------------------------------------
// trie_link_mem
// Link memory: one row per node holding all child links of that node.
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module trie_link_mem
  import trie_pkg::*;
(
  input  logic      clk,
  input  link_req_t req,
  output link_row_t rdata
);

  link_row_t mem [NODES];
  link_row_t rdata_r;

  // Write one row, read one row (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/trie_mark_mem.sv
// ----------------------------------------------------------------------------
// trie_mark_mem
// Word marks and has-children marks, one bit each per node. Both read at one
// address into registered outputs; each written through its own port.
// ----------------------------------------------------------------------------
module trie_mark_mem
  import trie_pkg::*;
(
  input  logic      clk,
  input  mark_req_t req,
  output mark_rd_t  rdata
);

  logic word_mem  [NODES];
  logic child_mem [NODES];
  logic word_rd_r;
  logic child_rd_r;

  // Word mark array
  always_ff @(posedge clk) begin
    if (req.word_we) begin
      word_mem[req.word_addr] <= req.word_bit;
    end
    if (req.rd_en) begin
      word_rd_r <= word_mem[req.rd_addr];
    end
  end

  // Has-children mark array
  always_ff @(posedge clk) begin
    if (req.child_we) begin
      child_mem[req.child_addr] <= req.child_bit;
    end
    if (req.rd_en) begin
      child_rd_r <= child_mem[req.rd_addr];
    end
  end

  assign rdata.is_word      = word_rd_r;
  assign rdata.has_children = child_rd_r;

endmodule

// File: src/trie_insert_lookup_engine_core.sv
// ----------------------------------------------------------------------------
// trie_insert_lookup_engine_core
// Letter-at-a-time insert and lookup engine over a node-array trie.
//
// Each input word carries one letter, an insert/lookup function and a flag
// for the last letter of a dictionary word; each produces exactly one result
// word. An item is worked in order: the link row of the current node is read
// from the link memory, then the link is followed (allocating a node on an
// insert if needed) while the marks of the reached node are read, then the
// result is registered once the result register is free. The next letter
// walks from the node this one reached, so one item is in flight at a time.
// After reset a clearing pass over all NODES rows zeroes the link and mark
// memories; no input is taken until it finishes. The result register lets a
// new item start while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module trie_insert_lookup_engine_core
  import trie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [LET_W-1:0]  in_letter,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [NODE_W-1:0] out_node,
  output logic              out_is_word,
  output logic              out_has_children,
  output logic              out_is_prefix,
  output logic              out_table_full,
  output logic              out_word_end
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LINK  = 4'b0100,
    ST_MARK  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic              missed_r, missed_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;

  // Item held while it is worked on
  logic              func_r;
  logic [LET_W-1:0]  letter_r;
  logic              last_r;
  logic              hit_r, hit_nxt;
  logic [NODE_W-1:0] reach_r, reach_nxt;
  logic              full_r, full_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [NODE_W-1:0] out_node_r;
  logic              out_is_word_r;
  logic              out_has_children_r;
  logic              out_table_full_r;
  logic              out_word_end_r;

  link_req_t         link_req;
  link_row_t         link_rd;
  mark_req_t         mark_req;
  mark_rd_t          mark_rd;

  logic              in_acc;
  logic              out_free;
  logic              walk_ok;
  logic [NODE_W-1:0] entry;
  logic              need_node;
  logic              alloc;
  logic              is_insert;
  link_row_t         row_upd;

  trie_link_mem u_link_mem (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rd)
  );

  trie_mark_mem u_mark_mem (
    .clk   (clk),
    .req   (mark_req),
    .rdata (mark_rd)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Follow the letter's link from the current node
  always_comb begin
    is_insert = (func_r == FUNC_INSERT);
    walk_ok   = !missed_r && (int'(letter_r) < LETTERS);
    entry     = link_rd[LIDX_W'(letter_r)];
    need_node = walk_ok && (entry == '0) && is_insert;
    alloc     = need_node && (free_r < FREE_W'(NODES));
    full_nxt  = need_node && !alloc;
    reach_nxt = alloc ? free_r[NODE_W-1:0] : entry;
    hit_nxt   = walk_ok && (reach_nxt != '0);
    row_upd   = link_rd;
    row_upd[LIDX_W'(letter_r)] = free_r[NODE_W-1:0];
  end

  // Memory requests
  always_comb begin
    link_req       = '0;
    mark_req       = '0;
    case (state_r)
      ST_CLEAR: begin
        link_req.we         = 1'b1;
        link_req.wr_addr    = clr_r;
        mark_req.word_we    = 1'b1;
        mark_req.word_addr  = clr_r;
        mark_req.child_we   = 1'b1;
        mark_req.child_addr = clr_r;
      end
      ST_IDLE: begin
        link_req.rd_en   = in_acc;
        link_req.rd_addr = cur_r;
      end
      ST_LINK: begin
        link_req.we         = alloc;
        link_req.wr_addr    = cur_r;
        link_req.wdata      = row_upd;
        mark_req.rd_en      = hit_nxt;
        mark_req.rd_addr    = reach_nxt;
        mark_req.word_we    = hit_nxt && is_insert && last_r;
        mark_req.word_addr  = reach_nxt;
        mark_req.word_bit   = 1'b1;
        mark_req.child_we   = alloc;
        mark_req.child_addr = cur_r;
        mark_req.child_bit  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequence control and walk state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    missed_nxt    = missed_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_W'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if (alloc) begin
          free_nxt = free_r + 1'b1;
        end
        if (last_r) begin
          cur_nxt    = '0;
          missed_nxt = 1'b0;
        end else if (hit_nxt) begin
          cur_nxt = reach_nxt;
        end else begin
          cur_nxt    = '0;
          missed_nxt = 1'b1;
        end
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      missed_r    <= 1'b0;
      free_r      <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      missed_r    <= missed_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item and the link outcome
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_func;
      letter_r <= in_letter;
      last_r   <= in_last;
    end
    if (state_r == ST_LINK) begin
      hit_r   <= hit_nxt;
      reach_r <= reach_nxt;
      full_r  <= full_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if ((state_r == ST_MARK) && out_free) begin
      out_hit_r          <= hit_r;
      out_node_r         <= hit_r ? reach_r : '0;
      out_is_word_r      <= hit_r && (mark_rd.is_word || (func_r == FUNC_INSERT && last_r));
      out_has_children_r <= hit_r && mark_rd.has_children;
      out_table_full_r   <= full_r;
      out_word_end_r     <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_node         = out_node_r;
  assign out_is_word      = out_is_word_r;
  assign out_has_children = out_has_children_r;
  assign out_is_prefix    = out_is_word_r || out_has_children_r;
  assign out_table_full   = out_table_full_r;
  assign out_word_end     = out_word_end_r;

`ifndef NO_ASSERTIONS
  // Free-node pointer never runs past the table
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(NODES))
    else $error("free node pointer beyond table");

  // A missed result carries no node and no marks
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_node_r == '0 && !out_is_word_r
                                     && !out_has_children_r))
    else $error("missed result with node or marks");

  // Overflow never comes with a hit
  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_table_full_r) |-> !out_hit_r)
    else $error("table full reported on a hit");

  // A new result appears only from the mark state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MARK))
    else $error("result raised outside mark state");

  // A new link is written only while a node is still free
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK && link_req.we) |=> (free_r == $past(free_r) + 1'b1))
    else $error("link written without allocation");
`endif

endmodule

// File: tb/tb_trie_insert_lookup_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trie_insert_lookup_engine_core
// Drives letter words into the trie engine and checks every result word
// against a mirror of the dictionary. The mirror holds its own link table and
// marks. The run has four parts:
// - directed words: misses, letters past Z, mixed insert and lookup, prefixes
// - random words, with shared prefixes and noise letters
// - a stretch of long inserted words with no idling on either side
// - a closing mix of fresh inserts and lookups of stored words
// ----------------------------------------------------------------------------
module tb_trie_insert_lookup_engine_core;
  import trie_pkg::*;

  // One result word, in port order
  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] node;
    logic              is_word;
    logic              has_children;
    logic              is_prefix;
    logic              table_full;
    logic              word_end;
  } walk_result_t;

  // Mirror of the dictionary; predicts and checks the result words
  class trie_mirror;
    bit [NODE_W-1:0] links [NODES][LETTERS];
    bit              word_mark [NODES];
    bit              child_mark [NODES];
    int unsigned     next_node;
    bit [NODE_W-1:0] walk_node;
    bit              walk_lost;
    walk_result_t    pending_results [$];
    int              errors;
    int              results_seen;
    int              hits;
    int              overflows;
    int              words_done;

    function new();
      next_node    = 1;
      walk_node    = '0;
      walk_lost    = 1'b0;
      errors       = 0;
      results_seen = 0;
      hits         = 0;
      overflows    = 0;
      words_done   = 0;
    endfunction

    // Walk one accepted letter and queue the result word it causes
    function void take_letter(logic func, logic [LET_W-1:0] letter, logic last);
      walk_result_t    r;
      bit [NODE_W-1:0] child;
      r     = '0;
      child = '0;
      if (!walk_lost && letter < LETTERS) begin
        child = links[walk_node][letter];
        // Allocate a node on an insert that finds no link
        if (child == 0 && func == FUNC_INSERT) begin
          if (next_node >= NODES) begin
            r.table_full = 1'b1;
          end else begin
            child = NODE_W'(next_node);
            next_node++;
            links[walk_node][letter] = child;
            child_mark[walk_node]    = 1'b1;
          end
        end
        if (child != 0) begin
          if (func == FUNC_INSERT && last) word_mark[child] = 1'b1;
          r.hit          = 1'b1;
          r.node         = child;
          r.is_word      = word_mark[child];
          r.has_children = child_mark[child];
          r.is_prefix    = word_mark[child] | child_mark[child];
        end
      end
      r.word_end = last;
      // Return to the root after the last letter, else advance or drop the walk
      if (last) begin
        walk_node = '0;
        walk_lost = 1'b0;
      end else if (r.hit) begin
        walk_node = r.node;
      end else begin
        walk_node = '0;
        walk_lost = 1'b1;
      end
      hits       += r.hit;
      overflows  += r.table_full;
      words_done += last;
      pending_results = {pending_results, r};
    endfunction

    // Count a mismatch; keep the log short on a broken build
    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH %s", msg);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d",
                         results_seen, name, got, want));
    endtask

    // Compare one accepted result word with the oldest prediction
    task match_result(walk_result_t got);
      walk_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with none expected, node %0d", got.node));
        return;
      end
      want = pending_results.pop_front();
      check_field("hit", got.hit, want.hit);
      check_field("node", got.node, want.node);
      check_field("is_word", got.is_word, want.is_word);
      check_field("has_children", got.has_children, want.has_children);
      check_field("is_prefix", got.is_prefix, want.is_prefix);
      check_field("table_full", got.table_full, want.table_full);
      check_field("word_end", got.word_end, want.word_end);
      results_seen++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_func = FUNC_INSERT;
  logic [LET_W-1:0]  in_letter = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [NODE_W-1:0] out_node;
  logic              out_is_word;
  logic              out_has_children;
  logic              out_is_prefix;
  logic              out_table_full;
  logic              out_word_end;

  trie_mirror book = new();

  // Percent of cycles each side idles
  int idle_pct = 23;
  int letters_sent = 0;

  // Word being built, and the words inserted so far
  logic [LET_W-1:0] spell [0:31];
  int               spell_len = 0;
  logic [LET_W-1:0] dict_text [$];
  int               dict_start [$];
  int               dict_len [$];

  trie_insert_lookup_engine_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_letter        (in_letter),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_node         (out_node),
    .out_is_word      (out_is_word),
    .out_has_children (out_has_children),
    .out_is_prefix    (out_is_prefix),
    .out_table_full   (out_table_full),
    .out_word_end     (out_word_end)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Check each result word taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.match_result('{out_hit, out_node, out_is_word, out_has_children,
                          out_is_prefix, out_table_full, out_word_end});
  end

  // Send one letter word; called and returns at a falling edge
  task automatic push_letter(logic func, logic [LET_W-1:0] letter, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_letter <= letter;
    in_last   <= last;
    do @(posedge clk); while (!in_ready);
    book.take_letter(func, letter, last);
    letters_sent++;
    @(negedge clk);
  endtask

  // Send the built word; mixed picks the function per letter
  task automatic push_word(logic func, bit mixed);
    for (int i = 0; i < spell_len; i++)
      push_letter(mixed ? logic'($urandom_range(1)) : func, spell[i],
                  i == spell_len - 1);
  endtask

  function automatic void make_word(int len, int top);
    spell_len = len;
    for (int i = 0; i < len; i++) spell[i] = LET_W'($urandom_range(top));
  endfunction

  function automatic void keep_word();
    dict_start = {dict_start, dict_text.size()};
    dict_len   = {dict_len, spell_len};
    for (int i = 0; i < spell_len; i++) dict_text = {dict_text, spell[i]};
  endfunction

  // Load a stored word, cut to a prefix or stretched by a letter
  function automatic void pick_stored();
    int w;
    int sub;
    if (dict_len.size() == 0) begin
      make_word(3, 5);
      return;
    end
    w         = $urandom_range(dict_len.size() - 1);
    spell_len = dict_len[w];
    for (int i = 0; i < spell_len; i++) spell[i] = dict_text[dict_start[w] + i];
    sub = $urandom_range(3);
    if (sub == 1 && spell_len > 1) begin
      spell_len = $urandom_range(1, spell_len - 1);
    end else if (sub == 2) begin
      spell[spell_len] = LET_W'($urandom_range(25));
      spell_len++;
    end
  endfunction

  initial begin
    int roll;
    int n;
    int rand_end;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words; letter 0 is A, 25 is Z
    push_letter(FUNC_LOOKUP, 0, 1'b1);   // lookup in an empty trie
    push_letter(FUNC_INSERT, 0, 1'b1);   // first node
    push_letter(FUNC_INSERT, 25, 1'b0);
    push_letter(FUNC_INSERT, 25, 1'b1);
    push_letter(FUNC_LOOKUP, 25, 1'b1);  // strict prefix, not a word
    push_letter(FUNC_LOOKUP, 25, 1'b0);
    push_letter(FUNC_LOOKUP, 25, 1'b1);  // full word
    push_letter(FUNC_INSERT, 31, 1'b1);  // letters past Z never link
    push_letter(FUNC_INSERT, 26, 1'b0);
    push_letter(FUNC_INSERT, 0, 1'b1);   // insert after a miss adds nothing
    push_letter(FUNC_LOOKUP, 0, 1'b0);
    push_letter(FUNC_LOOKUP, 31, 1'b0);
    push_letter(FUNC_LOOKUP, 0, 1'b1);
    push_letter(FUNC_INSERT, 0, 1'b0);   // mixed functions in one word
    push_letter(FUNC_LOOKUP, 1, 1'b0);
    push_letter(FUNC_INSERT, 2, 1'b1);
    push_letter(FUNC_INSERT, 0, 1'b0);   // word that extends another word
    push_letter(FUNC_INSERT, 1, 1'b1);
    push_letter(FUNC_LOOKUP, 0, 1'b1);   // both word and prefix
    push_letter(FUNC_LOOKUP, 16, 1'b1);
    push_letter(FUNC_LOOKUP, 0, 1'b0);
    push_letter(FUNC_LOOKUP, 1, 1'b0);
    push_letter(FUNC_LOOKUP, 25, 1'b1);  // walk falls off below a word

    // Random words, mostly well formed, over small and full alphabets
    rand_end = letters_sent + 420;
    while (letters_sent < rand_end) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        make_word($urandom_range(1, 6), $urandom_range(1) ? 5 : 25);
        keep_word();
        push_word(FUNC_INSERT, 1'b0);
      end else if (roll < 60) begin
        pick_stored();
        push_word(FUNC_LOOKUP, 1'b0);
      end else if (roll < 70) begin
        make_word($urandom_range(1, 6), 25);
        push_word(FUNC_LOOKUP, 1'b0);
      end else if (roll < 78) begin
        pick_stored();
        push_word(FUNC_INSERT, 1'b0);
      end else if (roll < 88) begin
        pick_stored();
        push_word(FUNC_INSERT, 1'b1);
      end else begin
        // Noise: any letter code, any function, words cut anywhere
        n = $urandom_range(1, 4);
        repeat (n)
          push_letter(logic'($urandom_range(1)), LET_W'($urandom_range(31)),
                      logic'($urandom_range(1)));
      end
    end

    // Long inserted words with no idling on either side
    idle_pct = 0;
    repeat (10) begin
      make_word(12, 25);
      keep_word();
      push_word(FUNC_INSERT, 1'b0);
    end

    // Closing mix of fresh inserts and lookups of stored words
    idle_pct = 23;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0) begin
        make_word(4, 25);
        push_word(FUNC_INSERT, k % 4 == 2);
      end else begin
        pick_stored();
        push_word(FUNC_LOOKUP, 1'b0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then let any stray result word show up
    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d letters in %0d words; %0d results checked, %0d hits",
             letters_sent, book.words_done, book.results_seen, book.hits);
    $display("Allocated %0d of %0d nodes; %0d inserts hit a full table",
             book.next_node, NODES, book.overflows);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", book.pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/trie_pkg.sv
src/trie_link_mem.sv
src/trie_mark_mem.sv
src/trie_insert_lookup_engine_core.sv
tb/tb_trie_insert_lookup_engine_core.sv
